[rtl/core/kmvw_pkg.sv]
// Shared types and constants of the keystone mesh vertex warp.
package kmvw_pkg;

    // Configuration register file.
    localparam int NREG   = 8;
    localparam int CFG_IW = 3;
    localparam int CW     = 16;

    typedef enum logic [CFG_IW-1:0] {
        REG_BL_X,
        REG_BL_Y,
        REG_BR_X,
        REG_BR_Y,
        REG_TR_X,
        REG_TR_Y,
        REG_TL_X,
        REG_TL_Y
    } reg_idx_t;

    localparam logic signed [CW-1:0] CORNER_RESET [NREG] = '{
        -16'sd4096, -16'sd4096,
         16'sd4096, -16'sd4096,
         16'sd4096,  16'sd4096,
        -16'sd4096,  16'sd4096
    };

    // Grid index and texture coordinate widths.
    localparam int IDXW   = 4;
    localparam int IDXN   = 16;
    localparam int UVW    = 13;
    localparam int UV_ONE = 4096;
    localparam int FRACW  = 12;

    // Internal arithmetic widths.
    localparam int DW     = 17;   // corner differences
    localparam int D3W    = 18;   // second differences
    localparam int DETW   = 36;   // determinant, Q12.24
    localparam int GHW    = 37;   // numerators of g and h
    localparam int SPLIT  = 18;   // low half of a split multiplier operand
    localparam int PPW    = 36;   // partial products
    localparam int COEFW  = 54;   // per-coordinate coefficients
    localparam int NW     = 68;   // coordinate numerators
    localparam int DENW   = 52;   // common denominator
    localparam int QW     = 16;   // quotient bits
    localparam int NCOORD = 2;
    localparam int NTERM  = 5;

    // Item pipeline: stage that enters the divider, and total depth.
    localparam int DIV_IN = 12;
    localparam int NSTG   = DIV_IN + QW + 1;

    localparam logic [QW-1:0] SAT_POS = 16'h7FFF;
    localparam logic [QW-1:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic [UVW-1:0] u;
        logic [UVW-1:0] v;
        logic           degen;
    } tag_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QW-1:0] quo;
        logic          neg;
        logic          sat;
    } divc_t;

endpackage

[rtl/core/keystone_mesh_vertex_warp.sv]
// Keystone warp vertex generator: square-to-quad homography evaluated per grid point.
// Throughput: one word per cycle; the whole pipeline advances together, so the input
// is ready whenever the output register is empty or is being taken.
// Reset clears the valid bits and loads the corner registers with the unit square
// (-1,-1), (1,-1), (1,1), (-1,1); no clearing pass is needed.
module keystone_mesh_vertex_warp #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 9
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] grid_col, [7:4] grid_row

    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] out_x, [31:16] out_y, [44:32] tex_u,
                                   // [57:45] tex_v, [63:58] zero
    output logic        m_tuser    // [0] degenerate
);

    localparam int COL_SPAN = GRID_COLS - 1;
    localparam int ROW_SPAN = GRID_ROWS - 1;
    localparam int NSTG     = kmvw_pkg::NSTG;
    localparam int DIV_IN   = kmvw_pkg::DIV_IN;
    localparam int QW       = kmvw_pkg::QW;
    localparam int NW       = kmvw_pkg::NW;
    localparam int DENW     = kmvw_pkg::DENW;
    localparam int DW       = kmvw_pkg::DW;
    localparam int D3W      = kmvw_pkg::D3W;
    localparam int DETW     = kmvw_pkg::DETW;
    localparam int GHW      = kmvw_pkg::GHW;
    localparam int PPW      = kmvw_pkg::PPW;
    localparam int COEFW    = kmvw_pkg::COEFW;
    localparam int SPLIT    = kmvw_pkg::SPLIT;
    localparam int UVW      = kmvw_pkg::UVW;
    localparam int FRACW    = kmvw_pkg::FRACW;
    localparam int NCOORD   = kmvw_pkg::NCOORD;
    localparam int NTERM    = kmvw_pkg::NTERM;
    localparam int CW       = kmvw_pkg::CW;
    localparam int IDXW     = kmvw_pkg::IDXW;

    // ------------------------------------------------------------------
    // Texture coordinate tables: round(idx * 4096 / span), half up, with
    // indices past the last grid line clamped onto it.
    // ------------------------------------------------------------------
    logic [UVW-1:0] u_tab [kmvw_pkg::IDXN];
    logic [UVW-1:0] v_tab [kmvw_pkg::IDXN];

    for (genvar i = 0; i < kmvw_pkg::IDXN; i++) begin : g_uv_tab
        localparam int CI = (i > COL_SPAN) ? COL_SPAN : i;
        localparam int RI = (i > ROW_SPAN) ? ROW_SPAN : i;
        localparam int UQ = (CI * 2 * kmvw_pkg::UV_ONE + COL_SPAN) / (2 * COL_SPAN);
        localparam int VQ = (RI * 2 * kmvw_pkg::UV_ONE + ROW_SPAN) / (2 * ROW_SPAN);
        assign u_tab[i] = UVW'(UQ);
        assign v_tab[i] = UVW'(VQ);
    end

    // ------------------------------------------------------------------
    // Corner registers.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] corner_reg [kmvw_pkg::NREG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kmvw_pkg::NREG; i++)
            begin
                corner_reg[i] <= kmvw_pkg::CORNER_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            corner_reg[cfg_index] <= cfg_data;
        end
    end

    logic signed [CW-1:0] p0 [NCOORD];
    logic signed [CW-1:0] p1 [NCOORD];
    logic signed [CW-1:0] p2 [NCOORD];
    logic signed [CW-1:0] p3 [NCOORD];

    assign p0[0] = corner_reg[kmvw_pkg::REG_BL_X];
    assign p1[0] = corner_reg[kmvw_pkg::REG_BR_X];
    assign p2[0] = corner_reg[kmvw_pkg::REG_TR_X];
    assign p3[0] = corner_reg[kmvw_pkg::REG_TL_X];
    assign p0[1] = corner_reg[kmvw_pkg::REG_BL_Y];
    assign p1[1] = corner_reg[kmvw_pkg::REG_BR_Y];
    assign p2[1] = corner_reg[kmvw_pkg::REG_TR_Y];
    assign p3[1] = corner_reg[kmvw_pkg::REG_TL_Y];

    // ------------------------------------------------------------------
    // Coefficient pipeline. The user must change the corners only while
    // no word is in flight; the block does not enforce it. The registers
    // run freely: stage k is read only by item stages at least k deep.
    // ------------------------------------------------------------------
    logic signed [DW-1:0]    d1_reg [NCOORD];   // br - tr
    logic signed [DW-1:0]    d2_reg [NCOORD];   // tl - tr
    logic signed [D3W-1:0]   d3_reg [NCOORD];   // bl - br + tr - tl
    logic signed [DW-1:0]    e1_reg [NCOORD];   // br - bl
    logic signed [DW-1:0]    e3_reg [NCOORD];   // tl - bl
    logic signed [DETW-1:0]  pa_reg, pb_reg;
    logic signed [GHW-1:0]   pc_reg, pd_reg, pe_reg, pf_reg;
    logic                    affine_reg;
    logic signed [DETW-1:0]  det_reg;
    logic signed [GHW-1:0]   gn_reg, hn_reg;
    logic                    degdet_reg;
    logic signed [GHW-1:0]   tb [NTERM];
    logic signed [DW-1:0]    ta [NCOORD][NTERM];
    logic signed [PPW-1:0]   pplo_reg [NCOORD][NTERM];
    logic signed [PPW-1:0]   pphi_reg [NCOORD][NTERM];
    logic signed [COEFW-1:0] term_reg [NCOORD][NTERM];
    logic signed [COEFW-1:0] c1_reg [NCOORD];
    logic signed [COEFW-1:0] c3_reg [NCOORD];
    logic signed [COEFW-1:0] c0_reg [NCOORD];
    logic signed [DETW-1:0]  det_next;

    assign det_next = pa_reg - pb_reg;

    // Each coefficient term is a 17-bit operand times a 37-bit one; the wide
    // operand is split so that every multiplier stays small.
    always_comb
    begin
        tb[0] = GHW'(det_reg);
        tb[1] = gn_reg;
        tb[2] = GHW'(det_reg);
        tb[3] = hn_reg;
        tb[4] = GHW'(det_reg);
        for (int c = 0; c < NCOORD; c++)
        begin
            ta[c][0] = e1_reg[c];
            ta[c][1] = DW'(p1[c]);
            ta[c][2] = e3_reg[c];
            ta[c][3] = DW'(p3[c]);
            ta[c][4] = DW'(p0[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NCOORD; c++)
        begin
            d1_reg[c] <= DW'(p1[c]) - DW'(p2[c]);
            d2_reg[c] <= DW'(p3[c]) - DW'(p2[c]);
            d3_reg[c] <= D3W'(p0[c]) - D3W'(p1[c]) + D3W'(p2[c]) - D3W'(p3[c]);
            e1_reg[c] <= DW'(p1[c]) - DW'(p0[c]);
            e3_reg[c] <= DW'(p3[c]) - DW'(p0[c]);
        end

        pa_reg     <= DETW'(d1_reg[0]) * DETW'(d2_reg[1]);
        pb_reg     <= DETW'(d2_reg[0]) * DETW'(d1_reg[1]);
        pc_reg     <= GHW'(d3_reg[0]) * GHW'(d2_reg[1]);
        pd_reg     <= GHW'(d2_reg[0]) * GHW'(d3_reg[1]);
        pe_reg     <= GHW'(d1_reg[0]) * GHW'(d3_reg[1]);
        pf_reg     <= GHW'(d3_reg[0]) * GHW'(d1_reg[1]);
        affine_reg <= (d3_reg[0] == '0) && (d3_reg[1] == '0);

        // A parallelogram is affine; a zero determinant becomes one LSB.
        if (affine_reg)
        begin
            det_reg    <= DETW'(1);
            gn_reg     <= '0;
            hn_reg     <= '0;
            degdet_reg <= 1'b0;
        end
        else
        begin
            det_reg    <= (det_next == '0) ? DETW'(1) : det_next;
            gn_reg     <= pc_reg - pd_reg;
            hn_reg     <= pe_reg - pf_reg;
            degdet_reg <= (det_next == '0);
        end

        for (int c = 0; c < NCOORD; c++)
        begin
            for (int t = 0; t < NTERM; t++)
            begin
                pplo_reg[c][t] <= PPW'(ta[c][t]) * PPW'($signed({1'b0, tb[t][SPLIT-1:0]}));
                pphi_reg[c][t] <= PPW'(ta[c][t]) * PPW'($signed(tb[t][GHW-1:SPLIT]));
                term_reg[c][t] <= (COEFW'(pphi_reg[c][t]) <<< SPLIT)
                                + COEFW'(pplo_reg[c][t]);
            end
            c1_reg[c] <= term_reg[c][0] + term_reg[c][1];
            c3_reg[c] <= term_reg[c][2] + term_reg[c][3];
            c0_reg[c] <= term_reg[c][4];
        end
    end

    // ------------------------------------------------------------------
    // Item pipeline. All stages move together; valid bits travel along.
    // ------------------------------------------------------------------
    logic                  adv;
    logic [NSTG:1]         vld_reg;
    kmvw_pkg::tag_t        tg_reg [1:NSTG];
    kmvw_pkg::tag_t        tg_next [1:NSTG];

    logic signed [UVW:0]   su, sv;
    logic signed [DENW-1:0] gnu_reg, hnv_reg, d4k_reg;
    logic signed [NW-1:0]  ma_reg [NCOORD];
    logic signed [NW-1:0]  mb_reg [NCOORD];
    logic signed [NW-1:0]  mc_reg [NCOORD];
    logic signed [DENW-1:0] den_reg, denf_reg;
    logic signed [NW-1:0]  num_reg [NCOORD];
    logic signed [NW-1:0]  numf_reg [NCOORD];
    logic                  denz;
    logic [DENW-1:0]       ad_reg;
    logic [NW-1:0]         an_reg [NCOORD];
    logic                  ng_reg [NCOORD];

    // Divider stages: entry at index 0, one quotient bit per stage.
    kmvw_pkg::divc_t       dv_reg [NCOORD][QW+1];
    kmvw_pkg::divc_t       dv_next [NCOORD][QW+1];
    logic [DENW-1:0]       dd_reg [QW];
    logic [NW-1:0]         sh [QW];
    logic                  ge [NCOORD][QW];

    logic [QW-1:0]         outq_reg [NCOORD];

    assign adv      = !vld_reg[NSTG] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-1:1], s_tvalid};
        end
    end

    assign su   = $signed({1'b0, tg_reg[7].u});
    assign sv   = $signed({1'b0, tg_reg[7].v});
    assign denz = (den_reg == '0);

    always_comb
    begin
        tg_next[1].u     = u_tab[s_tdata[IDXW-1:0]];
        tg_next[1].v     = v_tab[s_tdata[2*IDXW-1:IDXW]];
        tg_next[1].degen = 1'b0;
        for (int i = 2; i <= NSTG; i++)
        begin
            tg_next[i] = tg_reg[i-1];
        end
        tg_next[10].degen = degdet_reg || denz;
    end

    // Restoring division of 2|N| + |d| by 2|d| gives |N|/|d| rounded half up.
    always_comb
    begin
        for (int c = 0; c < NCOORD; c++)
        begin
            dv_next[c][0].rem = (an_reg[c] << 1) + NW'(ad_reg);
            dv_next[c][0].quo = '0;
            dv_next[c][0].neg = ng_reg[c];
            dv_next[c][0].sat = an_reg[c] >= (NW'(ad_reg) << (QW - 1));
        end
        for (int j = 0; j < QW; j++)
        begin
            sh[j] = NW'(dd_reg[j]) << (QW - 1 - j);
            for (int c = 0; c < NCOORD; c++)
            begin
                ge[c][j]              = dv_reg[c][j].rem >= sh[j];
                dv_next[c][j+1].rem   = ge[c][j] ? (dv_reg[c][j].rem - sh[j])
                                                 : dv_reg[c][j].rem;
                dv_next[c][j+1].quo   = {dv_reg[c][j].quo[QW-2:0], ge[c][j]};
                dv_next[c][j+1].neg   = dv_reg[c][j].neg;
                dv_next[c][j+1].sat   = dv_reg[c][j].sat;
            end
        end
    end

    function automatic logic [QW-1:0] finish(input kmvw_pkg::divc_t d);
        logic [QW-1:0] r;
        if (d.sat)
        begin
            r = d.neg ? kmvw_pkg::SAT_NEG : kmvw_pkg::SAT_POS;
        end
        else if (d.neg)
        begin
            r = -d.quo;
        end
        else
        begin
            r = d.quo[QW-1] ? kmvw_pkg::SAT_POS : d.quo;
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 1; i <= NSTG; i++)
            begin
                tg_reg[i] <= tg_next[i];
            end

            // Products of the interpolation; coefficients are settled by now.
            gnu_reg <= DENW'(gn_reg) * DENW'(su);
            hnv_reg <= DENW'(hn_reg) * DENW'(sv);
            d4k_reg <= DENW'(det_reg) <<< FRACW;
            for (int c = 0; c < NCOORD; c++)
            begin
                ma_reg[c] <= NW'(c1_reg[c]) * NW'(su);
                mb_reg[c] <= NW'(c3_reg[c]) * NW'(sv);
                mc_reg[c] <= NW'(c0_reg[c]) <<< FRACW;
            end

            den_reg <= gnu_reg + hnv_reg + d4k_reg;
            for (int c = 0; c < NCOORD; c++)
            begin
                num_reg[c] <= ma_reg[c] + mb_reg[c] + mc_reg[c];
            end

            // A zero denominator takes one LSB with the sign of the determinant.
            if (denz)
            begin
                denf_reg <= det_reg[DETW-1] ? -DENW'(1) : DENW'(1);
            end
            else
            begin
                denf_reg <= den_reg;
            end
            for (int c = 0; c < NCOORD; c++)
            begin
                numf_reg[c] <= num_reg[c];
            end

            ad_reg <= denf_reg[DENW-1] ? DENW'(-denf_reg) : DENW'(denf_reg);
            for (int c = 0; c < NCOORD; c++)
            begin
                an_reg[c] <= numf_reg[c][NW-1] ? NW'(-numf_reg[c]) : NW'(numf_reg[c]);
                ng_reg[c] <= numf_reg[c][NW-1] != denf_reg[DENW-1];
            end

            dd_reg[0] <= ad_reg << 1;
            for (int j = 1; j < QW; j++)
            begin
                dd_reg[j] <= dd_reg[j-1];
            end
            for (int c = 0; c < NCOORD; c++)
            begin
                for (int j = 0; j <= QW; j++)
                begin
                    dv_reg[c][j] <= dv_next[c][j];
                end
                outq_reg[c] <= finish(dv_reg[c][QW]);
            end
        end
    end

    assign m_tdata = {6'b0, tg_reg[NSTG].v, tg_reg[NSTG].u, outq_reg[1], outq_reg[0]};
    assign m_tuser = tg_reg[NSTG].degen;

endmodule
